// ----- design/hpdd_pkg.sv -----
// ============================================================================
// hpdd_pkg
// Shared widths, register indexes, constants, microcode types and the
// microcode program of the heading PID differential-drive controller.
// ============================================================================
package hpdd_pkg;

  // Field and datapath widths
  localparam int ERR_W      = 9;    // wrapped heading error
  localparam int WIDE_W     = 11;   // raw heading difference before wrap
  localparam int DT_W       = 16;
  localparam int FWD_W      = 7;
  localparam int GAIN_W     = 10;
  localparam int LIM_W      = 16;
  localparam int SPD_W      = 16;
  localparam int INT_W      = 17;
  localparam int DERIV_W    = 20;
  localparam int MUL_A_W    = 20;
  localparam int MUL_B_W    = 17;
  localparam int MUL_P_W    = MUL_A_W + MUL_B_W + 1;
  localparam int PROD_W     = 31;
  localparam int DIV_W      = 30;   // dividend magnitude, two bits retired per cycle
  localparam int DVS_W      = 17;
  localparam int DIV_STEPS  = DIV_W / 2;
  localparam int DCNT_W     = $clog2(DIV_STEPS + 1);
  localparam int RCP_W      = 31;   // reciprocal constant
  localparam int RCP_P_W    = DIV_W + RCP_W;
  localparam int ACC_W      = 32;
  localparam int OUT_W      = 16;
  localparam int WHEEL_W    = 18;
  localparam int PC_W       = 4;
  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 16;
  localparam int IN_DATA_W  = 48;
  localparam int OUT_DATA_W = 48;

  // Configuration register indexes
  localparam logic [CFG_ADDR_W-1:0] REG_P_GAIN    = 3'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_I_GAIN    = 3'd1;
  localparam logic [CFG_ADDR_W-1:0] REG_D_GAIN    = 3'd2;
  localparam logic [CFG_ADDR_W-1:0] REG_INT_LIMIT = 3'd3;
  localparam logic [CFG_ADDR_W-1:0] REG_SPEED_MAX = 3'd4;
  localparam logic [CFG_ADDR_W-1:0] REG_SPEED_MIN = 3'd5;

  // Register reset values
  localparam logic [GAIN_W-1:0]       P_GAIN_RST    = 10'd65;
  localparam logic [GAIN_W-1:0]       I_GAIN_RST    = 10'd20;
  localparam logic [GAIN_W-1:0]       D_GAIN_RST    = 10'd20;
  localparam logic [LIM_W-1:0]        INT_LIMIT_RST = 16'd50000;
  localparam logic signed [SPD_W-1:0] SPEED_MAX_RST = 16'sd100;
  localparam logic signed [SPD_W-1:0] SPEED_MIN_RST = -16'sd100;

  // Arithmetic constants
  localparam logic signed [WIDE_W-1:0] WRAP_HI   = 11'sd180;
  localparam logic signed [WIDE_W-1:0] WRAP_LO   = -11'sd179;
  localparam logic signed [WIDE_W-1:0] WRAP_SPAN = 11'sd360;
  localparam logic [MUL_B_W-1:0]       K_DERIV   = 17'd1000;
  localparam logic signed [ACC_W-1:0]  CTRL_MAX  = 32'sd32767;
  localparam logic signed [ACC_W-1:0]  CTRL_MIN  = -32'sd32768;

  // Reciprocals for the constant divisors. With the shift set to the
  // dividend width plus the divisor's bit length, the rounded-up reciprocal
  // gives the exact truncated quotient for every dividend magnitude.
  localparam int GAIN_SHIFT  = DIV_W + 7;    // divide by 100
  localparam int ITERM_SHIFT = DIV_W + 17;   // divide by 100 times 1000
  localparam logic [RCP_W-1:0] GAIN_RCP  =
    RCP_W'(((64'd1 << GAIN_SHIFT) + 64'd99) / 64'd100);
  localparam logic [RCP_W-1:0] ITERM_RCP =
    RCP_W'(((64'd1 << ITERM_SHIFT) + 64'd99999) / 64'd100000);

  // Microcode fields
  typedef enum logic [2:0] {
    COND_NEXT,      // always advance to the next step
    COND_WAIT_IN,   // hold until an input transaction
    COND_IF_FUNC,   // branch to target on a clear item
    COND_WAIT_DIV,  // hold until the divider is idle
    COND_WAIT_OUT   // hold until the output register is free, then go to target
  } cond_t;

  typedef enum logic [3:0] {
    ALU_NOP,
    ALU_LATCH,
    ALU_ERR,
    ALU_INTEG,
    ALU_LAST,
    ALU_PUSH,
    ALU_MEAN,
    ALU_ACC_LOAD,
    ALU_ACC_ADD,
    ALU_SAT,
    ALU_OUT,
    ALU_CLEAR,
    ALU_OUT_ZERO
  } alu_op_t;

  typedef enum logic [2:0] {
    MUL_NONE,
    MUL_ERR_DT,
    MUL_DIFF_K,
    MUL_ERR_P,
    MUL_INT_I,
    MUL_MEAN_D
  } mul_sel_t;

  typedef enum logic [2:0] {
    DIV_NONE,
    DIV_DERIV,
    DIV_MEAN,
    DIV_PTERM,
    DIV_ITERM,
    DIV_DTERM
  } div_sel_t;

  typedef struct packed {
    cond_t            cond;
    alu_op_t          alu;
    mul_sel_t         mul;
    div_sel_t         div;
    logic [PC_W-1:0]  target;
  } uop_t;

  // Program steps
  localparam logic [PC_W-1:0] STEP_IDLE     = 4'd0;
  localparam logic [PC_W-1:0] STEP_ERR      = 4'd1;
  localparam logic [PC_W-1:0] STEP_MUL_INT  = 4'd2;
  localparam logic [PC_W-1:0] STEP_INTEG    = 4'd3;
  localparam logic [PC_W-1:0] STEP_DIV_DER  = 4'd4;
  localparam logic [PC_W-1:0] STEP_PUSH     = 4'd5;
  localparam logic [PC_W-1:0] STEP_DIV_MEAN = 4'd6;
  localparam logic [PC_W-1:0] STEP_MEAN     = 4'd7;
  localparam logic [PC_W-1:0] STEP_PTERM    = 4'd8;
  localparam logic [PC_W-1:0] STEP_ITERM    = 4'd9;
  localparam logic [PC_W-1:0] STEP_DTERM    = 4'd10;
  localparam logic [PC_W-1:0] STEP_SAT      = 4'd11;
  localparam logic [PC_W-1:0] STEP_OUT      = 4'd12;
  localparam logic [PC_W-1:0] STEP_CLEAR    = 4'd13;
  localparam logic [PC_W-1:0] STEP_CLR_OUT  = 4'd14;
  localparam logic [PC_W-1:0] STEP_LAST     = STEP_CLR_OUT;

  // Control store. A divider start in a wait step fires on the cycle the
  // previous division completes, so divisions run back to back.
  function automatic uop_t ucode(input logic [PC_W-1:0] pc);
    uop_t u;
    unique case (pc)
      STEP_IDLE:     u = '{COND_WAIT_IN,  ALU_LATCH,    MUL_NONE,   DIV_NONE,  STEP_IDLE};
      STEP_ERR:      u = '{COND_IF_FUNC,  ALU_ERR,      MUL_NONE,   DIV_NONE,  STEP_CLEAR};
      STEP_MUL_INT:  u = '{COND_NEXT,     ALU_NOP,      MUL_ERR_DT, DIV_NONE,  STEP_IDLE};
      STEP_INTEG:    u = '{COND_NEXT,     ALU_INTEG,    MUL_DIFF_K, DIV_NONE,  STEP_IDLE};
      STEP_DIV_DER:  u = '{COND_NEXT,     ALU_LAST,     MUL_NONE,   DIV_DERIV, STEP_IDLE};
      STEP_PUSH:     u = '{COND_WAIT_DIV, ALU_PUSH,     MUL_NONE,   DIV_NONE,  STEP_IDLE};
      STEP_DIV_MEAN: u = '{COND_NEXT,     ALU_NOP,      MUL_ERR_P,  DIV_MEAN,  STEP_IDLE};
      STEP_MEAN:     u = '{COND_WAIT_DIV, ALU_MEAN,     MUL_INT_I,  DIV_PTERM, STEP_IDLE};
      STEP_PTERM:    u = '{COND_WAIT_DIV, ALU_ACC_LOAD, MUL_MEAN_D, DIV_ITERM, STEP_IDLE};
      STEP_ITERM:    u = '{COND_WAIT_DIV, ALU_ACC_ADD,  MUL_NONE,   DIV_DTERM, STEP_IDLE};
      STEP_DTERM:    u = '{COND_WAIT_DIV, ALU_ACC_ADD,  MUL_NONE,   DIV_NONE,  STEP_IDLE};
      STEP_SAT:      u = '{COND_NEXT,     ALU_SAT,      MUL_NONE,   DIV_NONE,  STEP_IDLE};
      STEP_OUT:      u = '{COND_WAIT_OUT, ALU_OUT,      MUL_NONE,   DIV_NONE,  STEP_IDLE};
      STEP_CLEAR:    u = '{COND_NEXT,     ALU_CLEAR,    MUL_NONE,   DIV_NONE,  STEP_IDLE};
      STEP_CLR_OUT:  u = '{COND_WAIT_OUT, ALU_OUT_ZERO, MUL_NONE,   DIV_NONE,  STEP_IDLE};
      default:       u = '{COND_WAIT_OUT, ALU_NOP,      MUL_NONE,   DIV_NONE,  STEP_IDLE};
    endcase
    return u;
  endfunction

endpackage

// ----- design/heading_pid_differential_drive.sv -----
// ============================================================================
// heading_pid_differential_drive
// Heading PID controller with angle wrap, derivative averaging and
// differential wheel mixing, run by a microcoded sequencer.
// ============================================================================
// Usage:
//   Items arrive on the in_ channel. in_tuser selects the kind of item: 0 runs
//   one control step, 1 clears the integral, the previous error and the
//   derivative ring. Each item gives exactly one out_ transaction: zeros for a
//   clear item, else left and right wheel speeds and saturated control value.
//   A new item is taken only once the sequencer has put the previous result
//   in the output register. A run item's derivative is divided by the
//   elapsed time in the shared divider, which retires two quotient bits per
//   cycle. The ring mean and the P, I and D scaling divide by constants
//   through a reciprocal multiply in the same divider.
//   The result sits in an output register; the next item is accepted while
//   it waits, and the sequencer only stalls at its final step if the
//   receiver still has not taken the previous result.
//   Reset restores the register defaults, zeroes the controller state and
//   empties the output register. Configuration writes on cfg_ take effect
//   at the clock edge and must be made while no item is in flight.
// ============================================================================
module heading_pid_differential_drive
  import hpdd_pkg::*;
#(
  parameter int RING_DEPTH = 3
) (
  input  logic                  clk,
  input  logic                  rst_n,
  // in_tdata fields from bit 0: setpoint_heading[8:0], measured_heading[17:9],
  // elapsed_ms[33:18], forward_speed[40:34], zero pad [47:41]
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [IN_DATA_W-1:0]  in_tdata,
  // in_tuser fields from bit 0: func
  input  logic                  in_tuser,
  // out_tdata fields from bit 0: left_speed[15:0], right_speed[31:16],
  // control_value[47:32]
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [OUT_DATA_W-1:0] out_tdata,
  input  logic                  cfg_we,
  input  logic [CFG_ADDR_W-1:0] cfg_addr,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  localparam int PTR_W = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
  localparam int SUM_W = DERIV_W + $clog2(RING_DEPTH) + 1;
  localparam int MEAN_SHIFT = DIV_W + $clog2(RING_DEPTH);
  localparam logic [RCP_W-1:0] MEAN_RCP =
    RCP_W'(((64'd1 << MEAN_SHIFT) + 64'(RING_DEPTH) - 64'd1) / 64'(RING_DEPTH));

  // Configuration registers
  logic [GAIN_W-1:0]       p_gain_r, i_gain_r, d_gain_r;
  logic [LIM_W-1:0]        lim_r;
  logic signed [SPD_W-1:0] spd_max_r, spd_min_r;

  // Sequencer
  logic [PC_W-1:0] pc_r, pc_nxt;
  uop_t            uop;
  logic            go;
  logic            in_fire;
  logic            div_start;

  // Latched item
  logic                     func_r;
  logic signed [ERR_W-1:0]  sp_r, hd_r;
  logic [DT_W-1:0]          dt_r;
  logic [FWD_W-1:0]         fwd_r;

  // Controller state
  logic signed [INT_W-1:0]   integ_r, integ_nxt;
  logic signed [ERR_W-1:0]   last_r, last_nxt;
  logic signed [DERIV_W-1:0] ring_r [RING_DEPTH];
  logic signed [DERIV_W-1:0] ring_nxt [RING_DEPTH];
  logic signed [SUM_W-1:0]   sum_r, sum_nxt;
  logic [PTR_W-1:0]          ptr_r, ptr_nxt;

  // Scratch registers
  logic signed [ERR_W-1:0]   err_r, err_nxt;
  logic signed [PROD_W-1:0]  prod_r, prod_nxt;
  logic signed [DERIV_W-1:0] mean_r, mean_nxt;
  logic signed [ACC_W-1:0]   acc_r, acc_nxt;
  logic signed [OUT_W-1:0]   ctrl_r, ctrl_nxt;

  // Divider
  logic [DVS_W-1:0]         rem_r, rem_nxt;
  logic [DIV_W-1:0]         dq_r, dq_nxt;
  logic [DVS_W-1:0]         dvs_r, dvs_nxt;
  logic                     dneg_r, dneg_nxt;
  logic [DCNT_W-1:0]        dcnt_r, dcnt_nxt;
  div_sel_t                 dsel_r, dsel_nxt;
  logic [RCP_P_W-1:0]       rprod_r, rprod_nxt;
  logic [RCP_W-1:0]         rcp_k;
  logic [DIV_W-1:0]         qmag;
  logic                     div_busy;
  logic signed [PROD_W-1:0] div_x;
  logic signed [PROD_W-1:0] div_mag;
  logic signed [PROD_W-1:0] quot;

  // Multiplier
  logic signed [MUL_A_W-1:0] mul_a;
  logic [MUL_B_W-1:0]        mul_b;
  logic signed [MUL_P_W-1:0] mul_p;

  // Output register
  logic                  out_tvalid_r, out_tvalid_nxt;
  logic [OUT_DATA_W-1:0] out_tdata_r, out_tdata_nxt;

  // Combinational helpers
  logic signed [WIDE_W-1:0]  diff_w, wrap_w;
  logic signed [ACC_W-1:0]   int_sum, lim_w;
  logic signed [DERIV_W-1:0] deriv;
  logic signed [WHEEL_W-1:0] fwd_w, ctrl_w, left_w, right_w;

  function automatic logic [DVS_W+DIV_W-1:0] div_step(
    input logic [DVS_W-1:0] rem,
    input logic [DIV_W-1:0] dq,
    input logic [DVS_W-1:0] dvs
  );
    logic [DVS_W:0]   trial;
    logic [DVS_W-1:0] rem_o;
    logic             qbit;
    trial = {rem, dq[DIV_W-1]};
    if (trial >= {1'b0, dvs}) begin
      rem_o = DVS_W'(trial - {1'b0, dvs});
      qbit  = 1'b1;
    end else begin
      rem_o = trial[DVS_W-1:0];
      qbit  = 1'b0;
    end
    return {rem_o, dq[DIV_W-2:0], qbit};
  endfunction

  // Upper clamp first, lower second: the lower limit wins when they cross.
  function automatic logic signed [WHEEL_W-1:0] wheel_clamp(
    input logic signed [WHEEL_W-1:0] v,
    input logic signed [WHEEL_W-1:0] hi,
    input logic signed [WHEEL_W-1:0] lo
  );
    logic signed [WHEEL_W-1:0] t;
    t = (v > hi) ? hi : v;
    t = (t < lo) ? lo : t;
    return t;
  endfunction

  assign uop       = ucode(pc_r);
  assign in_tready = (uop.cond == COND_WAIT_IN);
  assign in_fire   = in_tvalid && in_tready;
  assign div_busy  = (dcnt_r != '0);
  assign div_start = go && (uop.div != DIV_NONE);

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;

  // ---------------------------------------------------------------------------
  // Sequencer: step advance and next step
  // ---------------------------------------------------------------------------
  always_comb begin
    go     = 1'b1;
    pc_nxt = pc_r + 1'b1;
    unique case (uop.cond)
      COND_NEXT:     go = 1'b1;
      COND_WAIT_IN:  go = in_fire;
      COND_IF_FUNC:  pc_nxt = func_r ? uop.target : pc_r + 1'b1;
      COND_WAIT_DIV: go = !div_busy;
      COND_WAIT_OUT: begin
        go     = !out_tvalid_r || out_tready;
        pc_nxt = uop.target;
      end
      default:       pc_nxt = STEP_IDLE;
    endcase
    if (!go) begin
      pc_nxt = pc_r;
    end
  end

  // ---------------------------------------------------------------------------
  // Shared multiplier and divider operand selection
  // ---------------------------------------------------------------------------
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (uop.mul)
      MUL_ERR_DT: begin
        mul_a = {{(MUL_A_W-ERR_W){err_r[ERR_W-1]}}, err_r};
        mul_b = {{(MUL_B_W-DT_W){1'b0}}, dt_r};
      end
      MUL_DIFF_K: begin
        mul_a = {{(MUL_A_W-ERR_W){err_r[ERR_W-1]}}, err_r}
              - {{(MUL_A_W-ERR_W){last_r[ERR_W-1]}}, last_r};
        mul_b = K_DERIV;
      end
      MUL_ERR_P: begin
        mul_a = {{(MUL_A_W-ERR_W){err_r[ERR_W-1]}}, err_r};
        mul_b = {{(MUL_B_W-GAIN_W){1'b0}}, p_gain_r};
      end
      MUL_INT_I: begin
        mul_a = {{(MUL_A_W-INT_W){integ_r[INT_W-1]}}, integ_r};
        mul_b = {{(MUL_B_W-GAIN_W){1'b0}}, i_gain_r};
      end
      MUL_MEAN_D: begin
        mul_a = mean_r;
        mul_b = {{(MUL_B_W-GAIN_W){1'b0}}, d_gain_r};
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign mul_p = mul_a * $signed({1'b0, mul_b});

  assign div_x = (uop.div == DIV_MEAN) ? {{(PROD_W-SUM_W){sum_r[SUM_W-1]}}, sum_r}
                                       : prod_r;

  // Divisions run on magnitudes so the quotient truncates toward zero.
  // Only the derivative divides by a variable; the constant divisors use a
  // reciprocal multiply whose product is registered before the quotient is read.
  assign div_mag = div_x[PROD_W-1] ? -div_x : div_x;

  always_comb begin
    case (dsel_r)
      DIV_MEAN:  rcp_k = MEAN_RCP;
      DIV_ITERM: rcp_k = ITERM_RCP;
      default:   rcp_k = GAIN_RCP;
    endcase
  end

  always_comb begin
    case (dsel_r)
      DIV_DERIV: qmag = dq_r;
      DIV_MEAN:  qmag = DIV_W'(rprod_r >> MEAN_SHIFT);
      DIV_ITERM: qmag = DIV_W'(rprod_r >> ITERM_SHIFT);
      default:   qmag = DIV_W'(rprod_r >> GAIN_SHIFT);
    endcase
  end

  assign quot = dneg_r ? -$signed({1'b0, qmag}) : $signed({1'b0, qmag});

  always_comb begin
    logic [DVS_W+DIV_W-1:0] s1, s2;
    s1        = div_step(rem_r, dq_r, dvs_r);
    s2        = div_step(s1[DVS_W+DIV_W-1:DIV_W], s1[DIV_W-1:0], dvs_r);
    rem_nxt   = rem_r;
    dq_nxt    = dq_r;
    dvs_nxt   = dvs_r;
    dneg_nxt  = dneg_r;
    dcnt_nxt  = dcnt_r;
    dsel_nxt  = dsel_r;
    rprod_nxt = rprod_r;
    if (div_start) begin
      rem_nxt  = '0;
      dq_nxt   = div_mag[DIV_W-1:0];
      dvs_nxt  = {{(DVS_W-DT_W){1'b0}}, dt_r};
      dneg_nxt = div_x[PROD_W-1];
      dsel_nxt = uop.div;
      dcnt_nxt = (uop.div == DIV_DERIV) ? DCNT_W'(DIV_STEPS) : DCNT_W'(1);
    end else if (div_busy) begin
      if (dsel_r == DIV_DERIV) begin
        rem_nxt = s2[DVS_W+DIV_W-1:DIV_W];
        dq_nxt  = s2[DIV_W-1:0];
      end else begin
        rprod_nxt = dq_r * rcp_k;
      end
      dcnt_nxt = dcnt_r - 1'b1;
    end
  end

  // ---------------------------------------------------------------------------
  // Datapath
  // ---------------------------------------------------------------------------
  assign diff_w = {{(WIDE_W-ERR_W){sp_r[ERR_W-1]}}, sp_r}
                - {{(WIDE_W-ERR_W){hd_r[ERR_W-1]}}, hd_r};
  assign wrap_w = (diff_w >= WRAP_HI) ? diff_w - WRAP_SPAN :
                  (diff_w < WRAP_LO)  ? diff_w + WRAP_SPAN : diff_w;

  assign int_sum = {{(ACC_W-INT_W){integ_r[INT_W-1]}}, integ_r}
                 + {{(ACC_W-PROD_W){prod_r[PROD_W-1]}}, prod_r};
  assign lim_w   = $signed({{(ACC_W-LIM_W){1'b0}}, lim_r});

  // A zero elapsed time gives a zero derivative sample.
  assign deriv = (dt_r == '0) ? '0 : quot[DERIV_W-1:0];

  assign fwd_w   = $signed({{(WHEEL_W-FWD_W){1'b0}}, fwd_r});
  assign ctrl_w  = {{(WHEEL_W-OUT_W){ctrl_r[OUT_W-1]}}, ctrl_r};
  assign left_w  = wheel_clamp(fwd_w + ctrl_w,
                               {{(WHEEL_W-SPD_W){spd_max_r[SPD_W-1]}}, spd_max_r},
                               {{(WHEEL_W-SPD_W){spd_min_r[SPD_W-1]}}, spd_min_r});
  assign right_w = wheel_clamp(fwd_w - ctrl_w,
                               {{(WHEEL_W-SPD_W){spd_max_r[SPD_W-1]}}, spd_max_r},
                               {{(WHEEL_W-SPD_W){spd_min_r[SPD_W-1]}}, spd_min_r});

  always_comb begin
    integ_nxt      = integ_r;
    last_nxt       = last_r;
    ring_nxt       = ring_r;
    sum_nxt        = sum_r;
    ptr_nxt        = ptr_r;
    err_nxt        = err_r;
    prod_nxt       = prod_r;
    mean_nxt       = mean_r;
    acc_nxt        = acc_r;
    ctrl_nxt       = ctrl_r;
    out_tdata_nxt  = out_tdata_r;
    out_tvalid_nxt = out_tvalid_r && !out_tready;

    if (go && uop.mul != MUL_NONE) begin
      prod_nxt = mul_p[PROD_W-1:0];
    end

    if (go) begin
      case (uop.alu)
        ALU_ERR:  err_nxt = wrap_w[ERR_W-1:0];
        ALU_INTEG: begin
          if (int_sum > lim_w) begin
            integ_nxt = lim_w[INT_W-1:0];
          end else if (int_sum < -lim_w) begin
            integ_nxt = INT_W'(-lim_w);
          end else begin
            integ_nxt = int_sum[INT_W-1:0];
          end
        end
        ALU_LAST: last_nxt = err_r;
        ALU_PUSH: begin
          // The ring sum is kept running: drop the overwritten sample, add the new one.
          ring_nxt[ptr_r] = deriv;
          sum_nxt = sum_r
                  - {{(SUM_W-DERIV_W){ring_r[ptr_r][DERIV_W-1]}}, ring_r[ptr_r]}
                  + {{(SUM_W-DERIV_W){deriv[DERIV_W-1]}}, deriv};
          ptr_nxt = (ptr_r == PTR_W'(RING_DEPTH - 1)) ? '0 : ptr_r + 1'b1;
        end
        ALU_MEAN:     mean_nxt = quot[DERIV_W-1:0];
        ALU_ACC_LOAD: acc_nxt = {{(ACC_W-PROD_W){quot[PROD_W-1]}}, quot};
        ALU_ACC_ADD:  acc_nxt = acc_r + {{(ACC_W-PROD_W){quot[PROD_W-1]}}, quot};
        ALU_SAT: begin
          if (acc_r > CTRL_MAX) begin
            ctrl_nxt = CTRL_MAX[OUT_W-1:0];
          end else if (acc_r < CTRL_MIN) begin
            ctrl_nxt = CTRL_MIN[OUT_W-1:0];
          end else begin
            ctrl_nxt = acc_r[OUT_W-1:0];
          end
        end
        ALU_OUT: begin
          out_tdata_nxt  = {ctrl_r, right_w[OUT_W-1:0], left_w[OUT_W-1:0]};
          out_tvalid_nxt = 1'b1;
        end
        ALU_CLEAR: begin
          integ_nxt = '0;
          last_nxt  = '0;
          sum_nxt   = '0;
          ptr_nxt   = '0;
          for (int k = 0; k < RING_DEPTH; k++) begin
            ring_nxt[k] = '0;
          end
        end
        ALU_OUT_ZERO: begin
          out_tdata_nxt  = '0;
          out_tvalid_nxt = 1'b1;
        end
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Registers
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p_gain_r  <= P_GAIN_RST;
      i_gain_r  <= I_GAIN_RST;
      d_gain_r  <= D_GAIN_RST;
      lim_r     <= INT_LIMIT_RST;
      spd_max_r <= SPEED_MAX_RST;
      spd_min_r <= SPEED_MIN_RST;
    end else if (cfg_we) begin
      case (cfg_addr)
        REG_P_GAIN:    p_gain_r  <= cfg_wdata[GAIN_W-1:0];
        REG_I_GAIN:    i_gain_r  <= cfg_wdata[GAIN_W-1:0];
        REG_D_GAIN:    d_gain_r  <= cfg_wdata[GAIN_W-1:0];
        REG_INT_LIMIT: lim_r     <= cfg_wdata[LIM_W-1:0];
        REG_SPEED_MAX: spd_max_r <= $signed(cfg_wdata[SPD_W-1:0]);
        REG_SPEED_MIN: spd_min_r <= $signed(cfg_wdata[SPD_W-1:0]);
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r         <= STEP_IDLE;
      dcnt_r       <= '0;
      out_tvalid_r <= 1'b0;
      integ_r      <= '0;
      last_r       <= '0;
      sum_r        <= '0;
      ptr_r        <= '0;
      for (int k = 0; k < RING_DEPTH; k++) begin
        ring_r[k] <= '0;
      end
    end else begin
      pc_r         <= pc_nxt;
      dcnt_r       <= dcnt_nxt;
      out_tvalid_r <= out_tvalid_nxt;
      integ_r      <= integ_nxt;
      last_r       <= last_nxt;
      sum_r        <= sum_nxt;
      ptr_r        <= ptr_nxt;
      ring_r       <= ring_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      func_r <= in_tuser;
      sp_r   <= $signed(in_tdata[8:0]);
      hd_r   <= $signed(in_tdata[17:9]);
      dt_r   <= in_tdata[33:18];
      fwd_r  <= in_tdata[40:34];
    end
    err_r       <= err_nxt;
    prod_r      <= prod_nxt;
    mean_r      <= mean_nxt;
    acc_r       <= acc_nxt;
    ctrl_r      <= ctrl_nxt;
    rem_r       <= rem_nxt;
    dq_r        <= dq_nxt;
    dvs_r       <= dvs_nxt;
    dneg_r      <= dneg_nxt;
    dsel_r      <= dsel_nxt;
    rprod_r     <= rprod_nxt;
    out_tdata_r <= out_tdata_nxt;
  end

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  a_div_no_restart: assert property (@(posedge clk) disable iff (!rst_n)
    div_start |-> (dcnt_r == '0))
    else $error("divider started while a division is in progress");

  a_pc_range: assert property (@(posedge clk) disable iff (!rst_n)
    pc_r <= STEP_LAST)
    else $error("sequencer left the program");

  a_accept_to_err: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> (pc_r == STEP_ERR))
    else $error("accepted item did not enter the error step");

  a_ptr_range: assert property (@(posedge clk) disable iff (!rst_n)
    int'(ptr_r) < RING_DEPTH)
    else $error("ring pointer out of range");

  a_out_from_step: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid_r) |->
      $past(go && (uop.alu == ALU_OUT || uop.alu == ALU_OUT_ZERO)))
    else $error("result raised outside an output step");

endmodule
